>>> design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// shared types and constants of the cuckoo hash table engine
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int NW          = $clog2(TABLE_DEPTH + 1);
    localparam int KW          = 64;
    localparam int HW          = 32;

    localparam logic [KW-1:0] EMPTY_KEY = '1;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] SIDE_ANY = 2'd0;
    localparam logic [1:0] SIDE_ONE = 2'd1;
    localparam logic [1:0] SIDE_TWO = 2'd2;

    localparam logic REG_TABLE_SIZE  = 1'b0;
    localparam logic REG_BASE_OFFSET = 1'b1;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [KW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage

>>> design/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module cht_mod import cht_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [HW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [4:0]    r_cnt, n_cnt;
    logic [HW-1:0] r_q, n_q;
    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_div, n_div;
    logic [NW:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_q[HW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = NW'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[NW-1:0];
            end
            n_q   = {r_q[HW-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(HW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

>>> design/cht_mem.sv
// ----------------------------------------------------------------------------
// cht_mem
// slot key store, one write and one registered read port
// ----------------------------------------------------------------------------
module cht_mem import cht_pkg::*; (
    input  logic          i_clk,
    input  t_mem_req      i_req,
    output logic [KW-1:0] o_rdata
);

    logic [KW-1:0] r_mem [TABLE_DEPTH];
    logic [KW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cuckoo_hash_table_engine.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table_engine
// two-choice cuckoo hash table of 64-bit keys: lookup, insert, remove
//
//   channel  direction  handshake          payload
//   request  in         i_valid / o_ready  i_operation, i_key
//   result   out        o_valid / i_ready  o_status, o_slot_address
//   config   in         i_cfg_we           i_cfg_index, i_cfg_data
//
// the serial remainder unit sets the pace of every hash
// lookup and remove hash, then read and compare the first slot and, unless it hits,
// the second; a reserved key or an unused operation skips the hashing
// insert then tries both slots for a free one, and each kick rehashes the evicted key
// after reset a clearing pass empties every slot of the store, o_ready low
// one transaction at a time; a result waiting in the output register does
// not block the next request until that one finishes
// ----------------------------------------------------------------------------
module cuckoo_hash_table_engine import cht_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_operation,
    input  logic [KW-1:0] i_key,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [31:0]   o_slot_address,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_MODM  = 14'b00000000000100,
        S_MODK  = 14'b00000000001000,
        S_FRDA  = 14'b00000000010000,
        S_FCMPA = 14'b00000000100000,
        S_FRDB  = 14'b00000001000000,
        S_FCMPB = 14'b00000010000000,
        S_KRDA  = 14'b00000100000000,
        S_KCMPA = 14'b00001000000000,
        S_KRDB  = 14'b00010000000000,
        S_KCMPB = 14'b00100000000000,
        S_KMOD  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [NW-1:0] r_size;
    logic [31:0]   r_base;
    logic [AW-1:0] r_clr, n_clr;
    logic [1:0]    r_op, n_op;
    logic [KW-1:0] r_hand, n_hand;
    logic [AW-1:0] r_m, n_m;
    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_b, n_b;
    logic [1:0]    r_side, n_side;
    logic [NW-1:0] r_depth, n_depth;
    logic          r_pass, n_pass;
    logic [AW-1:0] r_first, n_first;
    logic [1:0]    r_res_st, n_res_st;
    logic [AW-1:0] r_res_slot, n_res_slot;
    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_status, n_o_status;
    logic [31:0]   r_o_addr, n_o_addr;

    logic [NW-1:0] n_use;
    logic          mod_start;
    logic [HW-1:0] mod_dividend;
    logic          mod_done;
    logic [AW-1:0] mod_rem;
    logic [AW-1:0] rem_two;
    t_mem_req      mem_req;
    logic [KW-1:0] mem_rdata;
    logic [32:0]   addr_sum;
    logic          hit;
    logic [AW-1:0] hit_slot;
    logic [AW-1:0] evict_idx;
    logic          evict;

    always_comb begin
        if (r_size < NW'(2)) begin
            n_use = NW'(2);
        end else if (r_size > NW'(TABLE_DEPTH)) begin
            n_use = NW'(TABLE_DEPTH);
        end else begin
            n_use = r_size;
        end
    end

    // alternate hash from the remainder of all ones
    always_comb begin
        if (r_m >= mod_rem) begin
            rem_two = r_m - mod_rem;
        end else begin
            rem_two = AW'(({1'b0, r_m} + n_use) - {1'b0, mod_rem});
        end
    end

    cht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (n_use),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    cht_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign addr_sum = {1'b0, r_base} + 33'(r_res_slot);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_hand     = r_hand;
        n_m        = r_m;
        n_a        = r_a;
        n_b        = r_b;
        n_side     = r_side;
        n_depth    = r_depth;
        n_pass     = r_pass;
        n_first    = r_first;
        n_res_st   = r_res_st;
        n_res_slot = r_res_slot;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_addr   = r_o_addr;
        mod_start    = 1'b0;
        mod_dividend = r_hand[HW-1:0];
        mem_req      = '{we: 1'b0, waddr: r_a, wdata: r_hand, re: 1'b0, raddr: r_a};
        hit       = 1'b0;
        hit_slot  = r_a;
        evict     = 1'b0;
        evict_idx = r_b;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr;
                mem_req.wdata = EMPTY_KEY;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = i_operation;
                    n_hand = i_key;
                    if (i_key == EMPTY_KEY || (i_operation != OP_LOOKUP &&
                        i_operation != OP_INSERT && i_operation != OP_REMOVE)) begin
                        n_res_st = ST_MISS;
                        n_state  = S_DONE;
                    end else begin
                        mod_start    = 1'b1;
                        mod_dividend = '1;
                        n_state      = S_MODM;
                    end
                end
            end
            S_MODM: begin
                if (mod_done) begin
                    n_m       = mod_rem;
                    mod_start = 1'b1;
                    n_state   = S_MODK;
                end
            end
            S_MODK: begin
                if (mod_done) begin
                    n_a     = mod_rem;
                    n_b     = rem_two;
                    n_state = S_FRDA;
                end
            end
            S_FRDA: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_a;
                n_state       = S_FCMPA;
            end
            S_FCMPA: begin
                if (mem_rdata == r_hand) begin
                    hit      = 1'b1;
                    hit_slot = r_a;
                end else begin
                    n_state = S_FRDB;
                end
            end
            S_FRDB: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_b;
                n_state       = S_FCMPB;
            end
            S_FCMPB: begin
                hit      = (mem_rdata == r_hand);
                hit_slot = r_b;
                if (!hit) begin
                    if (r_op == OP_INSERT) begin
                        n_side  = SIDE_ANY;
                        n_depth = '0;
                        n_pass  = 1'b0;
                        n_state = S_KRDA;
                    end else begin
                        n_res_st = ST_MISS;
                        n_state  = S_DONE;
                    end
                end
            end
            S_KRDA: begin
                mem_req.re = 1'b1;
                if (r_side == SIDE_TWO) begin
                    mem_req.raddr = r_b;
                    n_state       = S_KCMPB;
                end else begin
                    mem_req.raddr = r_a;
                    n_state       = S_KCMPA;
                end
            end
            S_KCMPA: begin
                if (mem_rdata == EMPTY_KEY) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_a;
                    if (!r_pass && r_depth == '0) begin
                        n_first = r_a;
                    end
                    n_res_st = ST_DONE;
                    n_state  = S_DONE;
                end else if (r_side == SIDE_ONE) begin
                    evict     = 1'b1;
                    evict_idx = r_a;
                end else begin
                    n_state = S_KRDB;
                end
            end
            S_KRDB: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_b;
                n_state       = S_KCMPB;
            end
            S_KCMPB: begin
                if (mem_rdata == EMPTY_KEY) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_b;
                    if (!r_pass && r_depth == '0) begin
                        n_first = r_b;
                    end
                    n_res_st = ST_DONE;
                    n_state  = S_DONE;
                end else begin
                    evict     = 1'b1;
                    evict_idx = r_b;
                end
            end
            S_KMOD: begin
                if (mod_done) begin
                    n_a     = mod_rem;
                    n_b     = rem_two;
                    n_side  = (mod_rem == r_res_slot) ? SIDE_TWO : SIDE_ONE;
                    n_depth = r_depth + NW'(1);
                    n_state = S_KRDA;
                    if (r_depth + NW'(1) >= n_use) begin
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_depth = '0;
                            n_side  = (mod_rem == r_res_slot) ? SIDE_ONE : SIDE_TWO;
                        end else begin
                            n_res_st   = ST_FULL;
                            n_res_slot = r_first;
                            n_state    = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_st;
                    if (r_res_st == ST_MISS) begin
                        n_o_addr = '0;
                    end else if (addr_sum[32]) begin
                        n_o_addr = '1;
                    end else begin
                        n_o_addr = addr_sum[31:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (hit) begin
            n_res_slot = hit_slot;
            n_state    = S_DONE;
            if (r_op == OP_INSERT) begin
                n_res_st = ST_PRESENT;
            end else begin
                n_res_st = ST_DONE;
                if (r_op == OP_REMOVE) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = hit_slot;
                    mem_req.wdata = EMPTY_KEY;
                end
            end
        end

        if (evict) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = evict_idx;
            if (!r_pass && r_depth == '0) begin
                n_first = evict_idx;
            end
            n_res_slot   = evict_idx;
            n_hand       = mem_rdata;
            mod_start    = 1'b1;
            mod_dividend = mem_rdata[HW-1:0];
            n_state      = S_KMOD;
        end

        // placement slot reported for a completed insert
        if ((r_state == S_KCMPA || r_state == S_KCMPB) && n_state == S_DONE) begin
            n_res_slot = (!r_pass && r_depth == '0) ? mem_req.waddr : r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_size    <= NW'(TABLE_DEPTH);
            r_base    <= 32'd1;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TABLE_SIZE) begin
                    r_size <= i_cfg_data[NW-1:0];
                end else begin
                    r_base <= i_cfg_data;
                end
            end
        end
        r_op       <= n_op;
        r_hand     <= n_hand;
        r_m        <= n_m;
        r_a        <= n_a;
        r_b        <= n_b;
        r_side     <= n_side;
        r_depth    <= n_depth;
        r_pass     <= n_pass;
        r_first    <= n_first;
        r_res_st   <= n_res_st;
        r_res_slot <= n_res_slot;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_slot_address = r_o_addr;

endmodule

>>> design/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// port-level checks of the cuckoo hash table engine
// ----------------------------------------------------------------------------
module cht_checker import cht_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_slot_address
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot_address))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_MISS |-> o_slot_address == 32'd0)
        else $error("miss with nonzero address");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after a transaction");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("active after reset");

endmodule

bind cuckoo_hash_table_engine cht_checker u_cht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_slot_address (o_slot_address)
);
